### rtl/core/elm_pkg.sv
// ----------------------------------------------------------------------------
// Enclave lifecycle monitor package
// Shared types and codes: command opcodes, slot status codes, the slot
// record kept in the slot table, configuration register indexes and the
// controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package elm_pkg;

    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned CFG_IDX_W = 2;

    // Command opcodes.
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_DESTROY = 3'd1;
    localparam logic [2:0] OP_RUN     = 3'd2;
    localparam logic [2:0] OP_EXIT    = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MEM_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_CEILING = 2'd1;

    // Result codes.
    localparam logic RES_OK      = 1'b0;
    localparam logic RES_INVALID = 1'b1;

    // Slot status; free must encode as zero so an unwritten slot reads free.
    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_FRESH   = 2'd1,
        SLOT_IDLE    = 2'd2,
        SLOT_RUNNING = 2'd3
    } t_slot_status;

    // One entry of the slot table.
    typedef struct packed {
        t_slot_status      status;
        logic [ADDR_W-1:0] sec_lo;
        logic [ADDR_W-1:0] sec_hi;
        logic [ADDR_W-1:0] sh_lo;
        logic [ADDR_W-1:0] sh_hi;
        logic [ADDR_W-1:0] entry;
    } t_slot_rec;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_FETCH = 3'd1,
        S_LOOK  = 3'd2,
        S_SCAN  = 3'd3,
        S_WRITE = 3'd4
    } t_state;

endpackage

`default_nettype wire

### rtl/core/elm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module elm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/enclave_lifecycle_monitor_core.sv
// ----------------------------------------------------------------------------
// Enclave lifecycle monitor core
// Security-monitor command engine over a table of enclave slots held in a
// synchronous RAM. Commands create, destroy, run, exit and resume a slot.
//
// Usage:
// - Command channel: i_in_valid / o_in_stall with the opcode, slot id and
//   the entry address and region bounds of a create. One item is taken at a
//   time; o_in_stall is high while an item is being processed.
// - Result channel: o_out_valid / i_out_stall, one result item per command.
//   The result sits in an output register, so the next command is taken
//   while a result still waits for the receiver.
// - Configuration channel: i_cfg_valid / o_cfg_ready (always ready) writes
//   mem_floor (index 0) or mem_ceiling (index 1); other indexes are ignored.
// - Sequence: destroy, run, exit, resume and rejected opcodes pass from
//   acceptance through the read, look and write states; create also
//   passes a scan state that walks the slot table one slot per cycle
//   through the RAM read port for the overlap check. The next item is
//   taken in the idle state entered when the result is registered.
// - Reset clears the running state and the per-slot valid bits; a slot that
//   was never written reads as free with zero bounds, so no clearing pass
//   is needed. If the receiver stalls, a finished command waits in its
//   write cycle until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module enclave_lifecycle_monitor_core #(
    parameter int unsigned SLOT_COUNT = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Command channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [2:0]                    i_opcode,
    input  wire logic [3:0]                    i_slot_id,
    input  wire logic [elm_pkg::ADDR_W-1:0]    i_start_address,
    input  wire logic [elm_pkg::ADDR_W-1:0]    i_secure_low,
    input  wire logic [elm_pkg::ADDR_W-1:0]    i_secure_high,
    input  wire logic [elm_pkg::ADDR_W-1:0]    i_shared_low,
    input  wire logic [elm_pkg::ADDR_W-1:0]    i_shared_high,
    // Result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_result_code,
    output logic                               o_enclave_active,
    output logic      [3:0]                    o_active_slot,
    output logic      [elm_pkg::ADDR_W-1:0]    o_jump_address,
    output logic      [elm_pkg::ADDR_W-1:0]    o_grant_secure_low,
    output logic      [elm_pkg::ADDR_W-1:0]    o_grant_secure_high,
    output logic      [elm_pkg::ADDR_W-1:0]    o_grant_shared_low,
    output logic      [elm_pkg::ADDR_W-1:0]    o_grant_shared_high,
    // Configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [elm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [elm_pkg::ADDR_W-1:0]    i_cfg_data
);

    import elm_pkg::*;

    localparam int unsigned AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned CW     = $clog2(SLOT_COUNT + 1);
    localparam int unsigned VDEPTH = 1 << AW;
    localparam int unsigned RW     = $bits(t_slot_rec);

    // Controller and command registers.
    t_state            r_state, n_state;
    logic [2:0]        r_op;
    logic [3:0]        r_slot_id;
    t_slot_rec         r_new;
    logic              r_reg_ok;

    // Configuration registers.
    logic [ADDR_W-1:0] r_floor;
    logic [ADDR_W-1:0] r_ceil;

    // Running state.
    logic              r_running, n_running;
    logic [3:0]        r_run_slot, n_run_slot;

    // Slot table access.
    logic [VDEPTH-1:0] r_valid;
    logic              r_rd_vld;
    t_slot_rec         r_rec;
    t_slot_rec         rd_rec;
    logic [RW-1:0]     ram_q;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_slot_rec         wr_rec;

    // Overlap scan.
    logic [CW-1:0]     r_cnt;
    logic              r_pend;
    logic              r_clash;
    logic              scan_hit;
    logic              scan_issue;

    // Command decision.
    logic              id_ok;
    logic              legal;
    logic              cmd_ok;
    logic              entered;
    logic              proceed;
    logic [AW-1:0]     target;

    // Output registers.
    logic              r_out_valid;
    logic              r_res_code;
    logic              r_out_active;
    logic [3:0]        r_out_slot;
    logic [ADDR_W-1:0] r_out_jump;
    logic [ADDR_W-1:0] r_out_gsl;
    logic [ADDR_W-1:0] r_out_gsh;
    logic [ADDR_W-1:0] r_out_gshl;
    logic [ADDR_W-1:0] r_out_gshh;

    elm_ram #(
        .WIDTH (RW),
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_rec),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // A slot never written reads as free with zero bounds.
    assign rd_rec = r_rd_vld ? t_slot_rec'(ram_q) : t_slot_rec'('0);

    assign id_ok   = (r_slot_id < 4'(SLOT_COUNT));
    assign legal   = !r_running && id_ok;
    assign target  = (r_op == OP_EXIT) ? r_run_slot[AW-1:0] : r_slot_id[AW-1:0];
    assign proceed = !r_out_valid || !i_out_stall;

    // Half-open overlap of the new secure range with the slot just read.
    assign scan_hit = r_pend && (rd_rec.sec_hi > r_new.sec_lo)
                      && (r_new.sec_hi > rd_rec.sec_lo);
    assign scan_issue = (r_cnt < CW'(SLOT_COUNT));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = (r_op == OP_CREATE) ? S_SCAN : S_WRITE;
            end
            S_SCAN: begin
                if (!scan_issue && !r_pend) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (proceed) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory read control per state.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = target;
        unique case (r_state)
            S_FETCH: begin
                ram_re = 1'b1;
            end
            S_SCAN: begin
                ram_re    = scan_issue;
                ram_raddr = r_cnt[AW-1:0];
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Command decision and write-back record, used in the write state.
    always_comb begin
        cmd_ok     = 1'b0;
        entered    = 1'b0;
        wr_rec     = r_rec;
        ram_waddr  = target;
        n_running  = r_running;
        n_run_slot = r_run_slot;
        unique case (r_op)
            OP_EXIT: begin
                cmd_ok        = r_running;
                wr_rec.status = SLOT_IDLE;
                if (cmd_ok) begin
                    n_running  = 1'b0;
                    n_run_slot = 4'd0;
                end
            end
            OP_CREATE: begin
                cmd_ok = legal && (r_rec.status == SLOT_FREE) && r_reg_ok && !r_clash;
                wr_rec = r_new;
            end
            OP_DESTROY: begin
                cmd_ok = legal && ((r_rec.status == SLOT_FRESH)
                                   || (r_rec.status == SLOT_IDLE));
                wr_rec.status = SLOT_FREE;
                wr_rec.sec_lo = '0;
                wr_rec.sec_hi = '0;
            end
            OP_RUN, OP_RESUME: begin
                if (r_op == OP_RUN) begin
                    cmd_ok = legal && ((r_rec.status == SLOT_FRESH)
                                       || (r_rec.status == SLOT_IDLE));
                end else begin
                    cmd_ok = legal && (r_rec.status == SLOT_IDLE);
                end
                wr_rec.status = SLOT_RUNNING;
                entered       = cmd_ok;
                if (cmd_ok) begin
                    n_running  = 1'b1;
                    n_run_slot = r_slot_id;
                end
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    assign ram_we = (r_state == S_WRITE) && proceed && cmd_ok;

    // Controller, command capture and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_running  <= 1'b0;
            r_run_slot <= 4'd0;
            r_valid    <= '0;
            r_floor    <= '0;
            r_ceil     <= '1;
            r_pend     <= 1'b0;
            r_cnt      <= '0;
            r_clash    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && (i_cfg_index == REG_MEM_FLOOR)) begin
                r_floor <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == REG_MEM_CEILING)) begin
                r_ceil <= i_cfg_data;
            end
            if (r_state == S_LOOK) begin
                r_cnt   <= '0;
                r_pend  <= 1'b0;
                r_clash <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_pend <= scan_issue;
                if (scan_issue) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                if (scan_hit) begin
                    r_clash <= 1'b1;
                end
            end
            if ((r_state == S_WRITE) && proceed) begin
                r_running  <= n_running;
                r_run_slot <= n_run_slot;
                if (ram_we) begin
                    r_valid[ram_waddr] <= 1'b1;
                end
            end
        end
    end

    // Payload registers: command fields, region check and read data.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op          <= i_opcode;
            r_slot_id     <= i_slot_id;
            r_new.status  <= SLOT_FRESH;
            r_new.sec_lo  <= i_secure_low;
            r_new.sec_hi  <= i_secure_high;
            r_new.sh_lo   <= i_shared_low;
            r_new.sh_hi   <= i_shared_high;
            r_new.entry   <= i_start_address;
        end
        if (r_state == S_FETCH) begin
            r_reg_ok <= (r_new.sec_lo < r_new.sec_hi) && (r_new.sec_lo >= r_floor)
                        && (r_new.sec_hi <= r_ceil) && (r_new.sh_lo < r_new.sh_hi)
                        && (r_new.sh_lo >= r_floor) && (r_new.sh_hi <= r_ceil);
        end
        if (ram_re) begin
            r_rd_vld <= r_valid[ram_raddr];
        end
        if (r_state == S_LOOK) begin
            r_rec <= rd_rec;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_WRITE) && proceed) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WRITE) && proceed) begin
            r_res_code   <= cmd_ok ? RES_OK : RES_INVALID;
            r_out_active <= n_running;
            r_out_slot   <= n_run_slot;
            r_out_jump   <= (entered && (r_op == OP_RUN)) ? r_rec.entry : '0;
            r_out_gsl    <= entered ? r_rec.sec_lo : '0;
            r_out_gsh    <= entered ? r_rec.sec_hi : '0;
            r_out_gshl   <= entered ? r_rec.sh_lo : '0;
            r_out_gshh   <= entered ? r_rec.sh_hi : '0;
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_out_valid         = r_out_valid;
    assign o_result_code       = r_res_code;
    assign o_enclave_active    = r_out_active;
    assign o_active_slot       = r_out_slot;
    assign o_jump_address      = r_out_jump;
    assign o_grant_secure_low  = r_out_gsl;
    assign o_grant_secure_high = r_out_gsh;
    assign o_grant_shared_low  = r_out_gshl;
    assign o_grant_shared_high = r_out_gshh;

    // The scan counter never passes the table size.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOT_COUNT))
        else $error("slot scan counter ran past the table");

    // The running slot always lies inside the table.
    a_run_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_run_slot < 4'(SLOT_COUNT)))
        else $error("running slot outside the table");

    // A table write completes the command.
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_state == S_IDLE) && r_out_valid)
        else $error("table write without a result");

    // A jump address is only reported with an enclave running.
    a_jump_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_jump != '0)) |-> (r_out_active && (r_res_code == RES_OK)))
        else $error("jump address without a successful run");

    // With no enclave running, the reported slot is zero.
    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_active) |-> (r_out_slot == 4'd0))
        else $error("active slot reported while nothing runs");

endmodule

`default_nettype wire
